// ----- hdl/tsc_pkg.sv -----
// shared widths, register codes and the record type for the subaperture centroid block
`default_nettype none

package tsc_pkg;

	// field widths
	localparam int PIX_W   = 16;
	localparam int THR_W   = 18;
	localparam int SIZE_W  = 7;
	localparam int FLUX_W  = 30;
	localparam int COUNT_W = 13;
	localparam int WSUM_W  = 36;
	localparam int CEN_W   = 14;

	// configuration port
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SUBAP_SIZE = 1'b1;

	// reset values of the registers
	localparam logic [THR_W-1:0]  THRESHOLD_RST  = '0;
	localparam logic [SIZE_W-1:0] SUBAP_SIZE_RST = 7'd16;

	// record queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// sums of one finished subaperture
	typedef struct packed {
		logic [FLUX_W-1:0]  flux;
		logic [COUNT_W-1:0] count;
		logic [WSUM_W-1:0]  wsum_x;
		logic [WSUM_W-1:0]  wsum_y;
	} tsc_rec_t;

endpackage

`default_nettype wire

// ----- hdl/tsc_front.sv -----
// front end: pixel correction, thresholding and per-subaperture accumulation
`default_nettype none

module tsc_front #(
	parameter int MAX_SUBAP_SIDE = 64,
	parameter int GAIN_FRAC_BITS = 14
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [tsc_pkg::PIX_W-1:0]    raw_pixel,
	input  wire  [tsc_pkg::PIX_W-1:0]    bias_level,
	input  wire  [tsc_pkg::PIX_W-1:0]    flat_gain,
	input  wire  [tsc_pkg::THR_W-1:0]    threshold,
	input  wire  [tsc_pkg::SIZE_W-1:0]   subap_size,
	input  wire                          q_full,
	output logic                         rec_push,
	output tsc_pkg::tsc_rec_t            rec
);

	localparam int IW   = $clog2(MAX_SUBAP_SIDE);
	localparam int CW   = (IW + 1 > tsc_pkg::SIZE_W) ? IW + 1 : tsc_pkg::SIZE_W;
	localparam int PW   = 2 * tsc_pkg::PIX_W;
	localparam int CRW  = PW - GAIN_FRAC_BITS;
	localparam int CMPW = (CRW > tsc_pkg::THR_W) ? CRW : tsc_pkg::THR_W;
	localparam int MW   = CRW + IW;

	logic          advance;
	logic          accept;
	logic [CW-1:0] size_c;
	logic [CW-1:0] side;
	logic          col_end;
	logic          row_end;
	logic [IW-1:0] col_q;
	logic [IW-1:0] row_q;

	logic          v_s1;
	logic          pos_s1;
	logic [PW-1:0] prod_s1;
	logic [IW-1:0] col_s1;
	logic [IW-1:0] row_s1;
	logic          last_s1;

	logic [CRW-1:0] corr;
	logic           pass;

	logic           v_s2;
	logic           pass_s2;
	logic [CRW-1:0] corr_s2;
	logic [MW-1:0]  wx_s2;
	logic [MW-1:0]  wy_s2;
	logic           last_s2;

	logic [tsc_pkg::FLUX_W-1:0]  flux_q;
	logic [tsc_pkg::COUNT_W-1:0] count_q;
	logic [tsc_pkg::WSUM_W-1:0]  wsx_q;
	logic [tsc_pkg::WSUM_W-1:0]  wsy_q;

	logic [tsc_pkg::FLUX_W:0]    flux_sum;
	logic [tsc_pkg::COUNT_W:0]   count_sum;
	logic [tsc_pkg::WSUM_W:0]    wsx_sum;
	logic [tsc_pkg::WSUM_W:0]    wsy_sum;
	tsc_pkg::tsc_rec_t           nxt;

	// the whole front holds while a finished record waits for queue space
	assign advance  = !(v_s2 && last_s2 && q_full);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	// side length clamped to 1..MAX_SUBAP_SIDE
	always_comb begin
		size_c = CW'(subap_size);
		if (size_c == '0) begin
			side = CW'(1);
		end else if (size_c > CW'(MAX_SUBAP_SIDE)) begin
			side = CW'(MAX_SUBAP_SIDE);
		end else begin
			side = size_c;
		end
		col_end = !(CW'({1'b0, col_q} + (IW + 1)'(1)) < side);
		row_end = !(CW'({1'b0, row_q} + (IW + 1)'(1)) < side);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!col_end) begin
				col_q <= col_q + IW'(1);
			end else begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + IW'(1);
			end
		end
	end

	// stage 1: bias subtraction and gain multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= raw_pixel > bias_level;
			prod_s1 <= PW'(raw_pixel - bias_level) * PW'(flat_gain);
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= col_end && row_end;
		end
	end

	// stage 2: threshold and position weighting
	assign corr = prod_s1[PW-1:GAIN_FRAC_BITS];
	assign pass = pos_s1 && (CMPW'(corr) > CMPW'(threshold));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			pass_s2 <= pass;
			corr_s2 <= corr;
			wx_s2   <= MW'(corr) * MW'(col_s1);
			wy_s2   <= MW'(corr) * MW'(row_s1);
			last_s2 <= last_s1;
		end
	end

	// stage 3: saturating accumulation
	always_comb begin
		flux_sum  = {1'b0, flux_q} + (tsc_pkg::FLUX_W + 1)'(corr_s2);
		count_sum = {1'b0, count_q} + (tsc_pkg::COUNT_W + 1)'(1);
		wsx_sum   = {1'b0, wsx_q} + (tsc_pkg::WSUM_W + 1)'(wx_s2);
		wsy_sum   = {1'b0, wsy_q} + (tsc_pkg::WSUM_W + 1)'(wy_s2);
		nxt.flux   = flux_q;
		nxt.count  = count_q;
		nxt.wsum_x = wsx_q;
		nxt.wsum_y = wsy_q;
		if (pass_s2) begin
			nxt.flux   = flux_sum[tsc_pkg::FLUX_W] ? '1 : flux_sum[tsc_pkg::FLUX_W-1:0];
			nxt.count  = count_sum[tsc_pkg::COUNT_W] ? '1 :
				count_sum[tsc_pkg::COUNT_W-1:0];
			nxt.wsum_x = wsx_sum[tsc_pkg::WSUM_W] ? '1 : wsx_sum[tsc_pkg::WSUM_W-1:0];
			nxt.wsum_y = wsy_sum[tsc_pkg::WSUM_W] ? '1 : wsy_sum[tsc_pkg::WSUM_W-1:0];
		end
	end

	assign rec_push = advance && v_s2 && last_s2;
	assign rec      = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flux_q  <= '0;
			count_q <= '0;
			wsx_q   <= '0;
			wsy_q   <= '0;
		end else if (advance && v_s2) begin
			if (last_s2) begin
				flux_q  <= '0;
				count_q <= '0;
				wsx_q   <= '0;
				wsy_q   <= '0;
			end else begin
				flux_q  <= nxt.flux;
				count_q <= nxt.count;
				wsx_q   <= nxt.wsum_x;
				wsy_q   <= nxt.wsum_y;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tsc_queue.sv -----
// two-entry queue of finished subaperture records
`default_nettype none

module tsc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  tsc_pkg::tsc_rec_t  wr_rec,
	input  wire                pop,
	output tsc_pkg::tsc_rec_t  rd_rec,
	output logic               full,
	output logic               empty
);

	tsc_pkg::tsc_rec_t               ent_q [tsc_pkg::Q_DEPTH];
	logic [tsc_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [tsc_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [tsc_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = cnt_q == tsc_pkg::Q_CNT_W'(tsc_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_rec  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + tsc_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tsc_pkg::Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + tsc_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - tsc_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tsc_back.sv -----
// back end: bit-serial centroid division and result register
`default_nettype none

module tsc_back #(
	parameter int CENTROID_FRAC_BITS = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            rec_avail,
	input  tsc_pkg::tsc_rec_t              rec,
	output logic                           rec_pop,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [tsc_pkg::CEN_W-1:0]      x_centroid,
	output logic [tsc_pkg::CEN_W-1:0]      y_centroid,
	output logic [tsc_pkg::FLUX_W-1:0]     flux_total,
	output logic [tsc_pkg::COUNT_W-1:0]    pixel_count,
	output logic                           centroid_valid
);

	localparam int DW  = tsc_pkg::WSUM_W + CENTROID_FRAC_BITS;
	localparam int STW = $clog2(DW);
	localparam int RW  = tsc_pkg::FLUX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic [STW-1:0]               step_q;
	logic [RW-1:0]                div_q;
	logic [RW-1:0]                rem_x_q;
	logic [RW-1:0]                rem_y_q;
	logic [DW-1:0]                dq_x_q;
	logic [DW-1:0]                dq_y_q;
	logic                         ok_q;
	logic [tsc_pkg::FLUX_W-1:0]   flux_q;
	logic [tsc_pkg::COUNT_W-1:0]  count_q;

	logic                         out_valid_q;
	logic [tsc_pkg::CEN_W-1:0]    x_q;
	logic [tsc_pkg::CEN_W-1:0]    y_q;
	logic [tsc_pkg::FLUX_W-1:0]   oflux_q;
	logic [tsc_pkg::COUNT_W-1:0]  ocount_q;
	logic                         ovalid_q;

	logic [RW:0]   tx;
	logic [RW:0]   ty;
	logic          gex;
	logic          gey;
	logic [RW-1:0] nrem_x;
	logic [RW-1:0] nrem_y;
	logic [RW:0]   dx;
	logic [RW:0]   dy;
	logic          out_free;

	// one restoring step for both centroids, same divisor
	always_comb begin
		tx     = {rem_x_q, dq_x_q[DW-1]};
		ty     = {rem_y_q, dq_y_q[DW-1]};
		gex    = tx >= {1'b0, div_q};
		gey    = ty >= {1'b0, div_q};
		dx     = tx - {1'b0, div_q};
		dy     = ty - {1'b0, div_q};
		nrem_x = gex ? dx[RW-1:0] : tx[RW-1:0];
		nrem_y = gey ? dy[RW-1:0] : ty[RW-1:0];
	end

	assign rec_pop  = (state_q == ST_IDLE) && rec_avail;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a taken result clears the register unless the next one loads now
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rec_avail) begin
						div_q   <= rec.flux;
						rem_x_q <= '0;
						rem_y_q <= '0;
						dq_x_q  <= DW'(rec.wsum_x) << CENTROID_FRAC_BITS;
						dq_y_q  <= DW'(rec.wsum_y) << CENTROID_FRAC_BITS;
						ok_q    <= (rec.count != '0) && (rec.flux != '0);
						flux_q  <= rec.flux;
						count_q <= rec.count;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_x_q <= nrem_x;
					rem_y_q <= nrem_y;
					dq_x_q  <= {dq_x_q[DW-2:0], gex};
					dq_y_q  <= {dq_y_q[DW-2:0], gey};
					step_q  <= step_q + STW'(1);
					if (step_q == STW'(DW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						x_q         <= ok_q ? dq_x_q[tsc_pkg::CEN_W-1:0] : '0;
						y_q         <= ok_q ? dq_y_q[tsc_pkg::CEN_W-1:0] : '0;
						oflux_q     <= ok_q ? flux_q : '0;
						ocount_q    <= ok_q ? count_q : '0;
						ovalid_q    <= ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign x_centroid     = x_q;
	assign y_centroid     = y_q;
	assign flux_total     = oflux_q;
	assign pixel_count    = ocount_q;
	assign centroid_valid = ovalid_q;

endmodule

`default_nettype wire

// ----- hdl/thresholded_subaperture_centroid.sv -----
// top level of the thresholded subaperture centroid block
`default_nettype none

// channel   handshake                 payload
// -------   -----------------------   -----------------------------------------------
// in        in_valid / in_stall       raw_pixel, bias_level, flat_gain
// out       out_valid / out_stall     x_centroid, y_centroid, flux_total, pixel_count,
//                                     centroid_valid
// cfg       psel/penable/pwrite       paddr, pwdata, prdata (0: threshold, 4: subap_size)
//
// cycles: the front takes one pixel item per clock unless in_stall holds it; a pixel
//   passes the stage 1 and stage 2 registers on its way to the accumulators
// the back divides one subaperture at a time and takes no new record until its result
//   is in the result register, one quotient bit per clock in a restoring divider;
//   subapertures with fewer pixels than the divide takes clocks are paced by the divider
// a two-entry record queue lets the front run on while the back divides
// reset: arst_n clears indices, accumulators, pipe valids, queue pointers, the divider
//   state machine and the result valid; threshold resets to 0, subap_size to 16
// stalls: in_stall rises only while a finished record waits for a full queue;
//   out_stall holds the result register, the divider then waits with its result

module thresholded_subaperture_centroid #(
	parameter int MAX_SUBAP_SIDE     = 64,
	parameter int GAIN_FRAC_BITS     = 14,
	parameter int CENTROID_FRAC_BITS = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// pixel items
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [tsc_pkg::PIX_W-1:0]      raw_pixel,
	input  wire  [tsc_pkg::PIX_W-1:0]      bias_level,
	input  wire  [tsc_pkg::PIX_W-1:0]      flat_gain,
	// result items
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [tsc_pkg::CEN_W-1:0]      x_centroid,
	output logic [tsc_pkg::CEN_W-1:0]      y_centroid,
	output logic [tsc_pkg::FLUX_W-1:0]     flux_total,
	output logic [tsc_pkg::COUNT_W-1:0]    pixel_count,
	output logic                           centroid_valid,
	// configuration
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [tsc_pkg::ADDR_W-1:0]     paddr,
	input  wire  [tsc_pkg::DATA_W-1:0]     pwdata,
	output logic [tsc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	logic [tsc_pkg::THR_W-1:0]      threshold_q;
	logic [tsc_pkg::SIZE_W-1:0]     subap_size_q;
	logic [tsc_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           cfg_wr;

	logic                           q_push;
	logic                           q_pop;
	logic                           q_full;
	logic                           q_empty;
	tsc_pkg::tsc_rec_t              q_wr_rec;
	tsc_pkg::tsc_rec_t              q_rd_rec;

	// register file: word address selects the register
	assign reg_idx = paddr[tsc_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= tsc_pkg::THRESHOLD_RST;
			subap_size_q <= tsc_pkg::SUBAP_SIZE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tsc_pkg::REG_THRESHOLD:  threshold_q  <= pwdata[tsc_pkg::THR_W-1:0];
				tsc_pkg::REG_SUBAP_SIZE: subap_size_q <= pwdata[tsc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tsc_pkg::REG_THRESHOLD:  prdata = tsc_pkg::DATA_W'(threshold_q);
			tsc_pkg::REG_SUBAP_SIZE: prdata = tsc_pkg::DATA_W'(subap_size_q);
			default:                 prdata = '0;
		endcase
	end

	// front: correction, threshold, accumulation per subaperture
	tsc_front #(
		.MAX_SUBAP_SIDE (MAX_SUBAP_SIDE),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_pixel  (raw_pixel),
		.bias_level (bias_level),
		.flat_gain  (flat_gain),
		.threshold  (threshold_q),
		.subap_size (subap_size_q),
		.q_full     (q_full),
		.rec_push   (q_push),
		.rec        (q_wr_rec)
	);

	// finished sums wait here for the divider
	tsc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_rec (q_wr_rec),
		.pop    (q_pop),
		.rd_rec (q_rd_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: centroid division and result register
	tsc_back #(
		.CENTROID_FRAC_BITS (CENTROID_FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_avail      (!q_empty),
		.rec            (q_rd_rec),
		.rec_pop        (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.x_centroid     (x_centroid),
		.y_centroid     (y_centroid),
		.flux_total     (flux_total),
		.pixel_count    (pixel_count),
		.centroid_valid (centroid_valid)
	);

	// a record is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("record pushed into full queue");

	// the front only stalls on a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled without a full queue");

	// a valid centroid always carries a nonzero count and flux
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && centroid_valid) |-> (pixel_count != '0 && flux_total != '0))
		else $error("valid centroid with empty sums");

	// an empty subaperture reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !centroid_valid) |->
		(x_centroid == '0 && y_centroid == '0 && flux_total == '0 && pixel_count == '0))
		else $error("empty subaperture with nonzero result");

endmodule

`default_nettype wire

// ----- tb/sv/thresholded_subaperture_centroid_tb.sv -----
// testbench for the thresholded subaperture centroid block: directed and random pixel streams
`default_nettype none

module thresholded_subaperture_centroid_tb;

	// block parameters, kept at their defaults
	localparam int MAX_SIDE  = 64;
	localparam int GAIN_FRAC = 14;
	localparam int CEN_FRAC  = 8;

	// saturation points of the accumulators
	localparam logic [63:0] FLUX_TOP  = (64'd1 << tsc_pkg::FLUX_W) - 64'd1;
	localparam logic [63:0] COUNT_TOP = (64'd1 << tsc_pkg::COUNT_W) - 64'd1;
	localparam logic [63:0] WSUM_TOP  = (64'd1 << tsc_pkg::WSUM_W) - 64'd1;

	// front pipe plus one full divide, with some slack
	localparam int SETTLE_CYCLES = 64;
	// the limit leaves ample room for the slowest run: size-1 subapertures paced by the divider,
	// receiver stalls, the long hold-off and a drain before every register write
	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_ITEMS  = 336;

	// one result item of the block
	typedef struct packed {
		logic [tsc_pkg::CEN_W-1:0]   x;
		logic [tsc_pkg::CEN_W-1:0]   y;
		logic [tsc_pkg::FLUX_W-1:0]  flux;
		logic [tsc_pkg::COUNT_W-1:0] count;
		logic                        valid;
	} centroid_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        in_valid = 1'b0;
	wire                         in_stall;
	logic [tsc_pkg::PIX_W-1:0]   raw_pixel = '0;
	logic [tsc_pkg::PIX_W-1:0]   bias_level = '0;
	logic [tsc_pkg::PIX_W-1:0]   flat_gain = '0;

	wire                         out_valid;
	logic                        out_stall = 1'b0;
	wire  [tsc_pkg::CEN_W-1:0]   x_centroid;
	wire  [tsc_pkg::CEN_W-1:0]   y_centroid;
	wire  [tsc_pkg::FLUX_W-1:0]  flux_total;
	wire  [tsc_pkg::COUNT_W-1:0] pixel_count;
	wire                         centroid_valid;

	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [tsc_pkg::ADDR_W-1:0]  paddr = '0;
	logic [tsc_pkg::DATA_W-1:0]  pwdata = '0;
	wire  [tsc_pkg::DATA_W-1:0]  prdata;
	wire                         pready;

	// our own copy of the registers and the accumulator state
	logic [tsc_pkg::THR_W-1:0]   thr_q = tsc_pkg::THRESHOLD_RST;
	logic [tsc_pkg::SIZE_W-1:0]  size_q = tsc_pkg::SUBAP_SIZE_RST;
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [63:0]        flux_acc = '0;
	logic [63:0]        pass_cnt = '0;
	logic [63:0]        xw_acc = '0;
	logic [63:0]        yw_acc = '0;

	// centroids still owed by the block, oldest first
	centroid_rec_t      pending_centroids[$];

	int                 errors = 0;
	int                 pixels_sent = 0;
	int                 results_seen = 0;
	int                 reg_writes = 0;
	int                 cycle_cnt = 0;
	bit                 quiet = 1'b0;
	int                 hold_left = 0;

	thresholded_subaperture_centroid #(
		.MAX_SUBAP_SIDE     (MAX_SIDE),
		.GAIN_FRAC_BITS     (GAIN_FRAC),
		.CENTROID_FRAC_BITS (CEN_FRAC)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.raw_pixel      (raw_pixel),
		.bias_level     (bias_level),
		.flat_gain      (flat_gain),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.x_centroid     (x_centroid),
		.y_centroid     (y_centroid),
		.flux_total     (flux_total),
		.pixel_count    (pixel_count),
		.centroid_valid (centroid_valid),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] clip(input logic [63:0] v, input logic [63:0] top);
		return (v > top) ? top : v;
	endfunction

	// side length actually used by the block: 0 acts as 1, oversize clamps to the max
	function automatic int unsigned eff_side(input logic [tsc_pkg::SIZE_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > MAX_SIDE)
			return MAX_SIDE;
		return 32'(s);
	endfunction

	// fold one pixel into the sums; returns 1 when the pixel closes a subaperture
	function automatic bit accumulate_pixel(input logic [tsc_pkg::PIX_W-1:0] raw,
			input logic [tsc_pkg::PIX_W-1:0] bias, input logic [tsc_pkg::PIX_W-1:0] gain,
			output centroid_rec_t rec);
		logic [63:0] r64, b64, g64, corr, q64;
		int unsigned side;
		r64 = 64'(raw);
		b64 = 64'(bias);
		g64 = 64'(gain);
		rec = '0;
		side = eff_side(size_q);
		// raw at or below bias never passes, threshold is never negative
		if (r64 > b64) begin
			corr = ((r64 - b64) * g64) >> GAIN_FRAC;
			// strictly above threshold
			if (corr > 64'(thr_q)) begin
				flux_acc = clip(flux_acc + corr, FLUX_TOP);
				pass_cnt = clip(pass_cnt + 64'd1, COUNT_TOP);
				xw_acc   = clip(xw_acc + corr * 64'(col_pos), WSUM_TOP);
				yw_acc   = clip(yw_acc + corr * 64'(row_pos), WSUM_TOP);
			end
		end
		// raster walk; a position already past a shrunken side ends the row at once
		if (col_pos + 1 < side) begin
			col_pos++;
			return 1'b0;
		end
		col_pos = 0;
		if (row_pos + 1 < side) begin
			row_pos++;
			return 1'b0;
		end
		// subaperture done: divide by flux, truncated; all zero when nothing passed
		if (pass_cnt != 0 && flux_acc != 0) begin
			q64 = (xw_acc << CEN_FRAC) / flux_acc;
			rec.x = q64[tsc_pkg::CEN_W-1:0];
			q64 = (yw_acc << CEN_FRAC) / flux_acc;
			rec.y = q64[tsc_pkg::CEN_W-1:0];
			rec.flux = flux_acc[tsc_pkg::FLUX_W-1:0];
			rec.count = pass_cnt[tsc_pkg::COUNT_W-1:0];
			rec.valid = 1'b1;
		end
		row_pos = 0;
		flux_acc = '0;
		pass_cnt = '0;
		xw_acc = '0;
		yw_acc = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
		end
	endtask

	// offer one pixel item, optionally after a short random gap, and wait for it to go in
	task automatic send_pixel(input logic [tsc_pkg::PIX_W-1:0] raw,
			input logic [tsc_pkg::PIX_W-1:0] bias, input logic [tsc_pkg::PIX_W-1:0] gain);
		centroid_rec_t rec;
		if (!quiet && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pixel <= raw;
		bias_level <= bias;
		flat_gain <= gain;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
		if (accumulate_pixel(raw, bias, gain, rec))
			pending_centroids.push_back(rec);
	endtask

	// pixel with random content: mostly a plausible frame, sometimes anything at all
	task automatic send_random_pixel();
		logic [tsc_pkg::PIX_W-1:0] raw, bias, gain;
		raw = tsc_pkg::PIX_W'($urandom);
		bias = ($urandom_range(0, 9) == 0) ? tsc_pkg::PIX_W'($urandom)
			: tsc_pkg::PIX_W'($urandom_range(0, 3000));
		gain = ($urandom_range(0, 9) < 7) ? tsc_pkg::PIX_W'($urandom_range(12000, 20000))
			: tsc_pkg::PIX_W'($urandom);
		send_pixel(raw, bias, gain);
	endtask

	// stop offering items, let every owed result come out, then let the front settle
	task automatic drain_all();
		in_valid <= 1'b0;
		while (pending_centroids.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one setup plus access transfer; psel stays high so transfers can chain
	task automatic apb_xfer(input bit wr, input logic [tsc_pkg::REG_IDX_W-1:0] idx,
			input logic [tsc_pkg::DATA_W-1:0] data,
			output logic [tsc_pkg::DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
	endtask

	// write a register while the block is idle, then read it back
	task automatic cfg_write(input logic [tsc_pkg::REG_IDX_W-1:0] idx,
			input logic [tsc_pkg::DATA_W-1:0] data);
		logic [tsc_pkg::DATA_W-1:0] rd;
		drain_all();
		apb_xfer(1'b1, idx, data, rd);
		if (idx == tsc_pkg::REG_THRESHOLD)
			thr_q = data[tsc_pkg::THR_W-1:0];
		else
			size_q = data[tsc_pkg::SIZE_W-1:0];
		reg_writes++;
		apb_xfer(1'b0, idx, '0, rd);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == tsc_pkg::REG_THRESHOLD)
			check_field("threshold readback", 64'(thr_q), 64'(rd));
		else
			check_field("subap_size readback", 64'(size_q), 64'(rd));
	endtask

	// registers come up at their reset values
	task automatic test_reset_values();
		logic [tsc_pkg::DATA_W-1:0] rd_thr, rd_size;
		apb_xfer(1'b0, tsc_pkg::REG_THRESHOLD, '0, rd_thr);
		apb_xfer(1'b0, tsc_pkg::REG_SUBAP_SIZE, '0, rd_size);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("threshold after reset", 64'(tsc_pkg::THRESHOLD_RST), 64'(rd_thr));
		check_field("subap_size after reset", 64'(tsc_pkg::SUBAP_SIZE_RST), 64'(rd_size));
	endtask

	// extremes of the pixel fields on a 2x2 subaperture
	task automatic test_field_extremes();
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd2);
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd0);
		// brightest corner, negative difference, raw equal to bias, zero gain
		send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h1234, 16'h1234, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000, 16'h0000);
		// all-zero pixel, all-ones pixel, smallest passing value, near-full pixel
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h8000, 16'h7FFF, 16'h4000);
		send_pixel(16'hFFFF, 16'h0001, 16'hFFFF);
		// nothing passes: invalid result with zero centroids
		repeat (4) send_pixel(16'h0000, 16'h0001, 16'hFFFF);
		drain_all();
	endtask

	// pass is strictly above the threshold; maximum threshold rejects everything
	task automatic test_threshold_edges();
		// upper pwdata bits set, only the low 18 land in the register
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'hFFFC_0000 | 32'd1000);
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd1);
		send_pixel(16'd1000, 16'd0, 16'd16384);
		send_pixel(16'd1001, 16'd0, 16'd16384);
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd262143);
		send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		drain_all();
	endtask

	// size 0 behaves as 1
	task automatic test_size_zero();
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd0);
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'hFFFF_FF80);
		send_pixel(16'd500, 16'd100, 16'd16384);
		send_pixel(16'd100, 16'd500, 16'd16384);
		drain_all();
	endtask

	// register writes in the middle of a subaperture
	task automatic test_mid_subaperture_write();
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd4);
		repeat (6) send_random_pixel();
		// position is row 1 col 2, beyond a side of 2: the next pixel closes it
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd2);
		send_random_pixel();
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd3);
		repeat (4) send_random_pixel();
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd3000);
		repeat (5) send_random_pixel();
		drain_all();
	endtask

	// oversize setting clamps to the max side: one full-scale row up to the last
	// column, then a shrink to 1 closes the subaperture on row 1
	task automatic test_full_size();
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd0);
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd127);
		repeat (MAX_SIDE) send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd1);
		send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		drain_all();
	endtask

	// receiver holds off while single-pixel subapertures pile up and stall the input
	task automatic test_backpressure();
		cfg_write(tsc_pkg::REG_THRESHOLD, 32'd0);
		cfg_write(tsc_pkg::REG_SUBAP_SIZE, 32'd1);
		hold_left = 400;
		repeat (16) send_random_pixel();
		drain_all();
	endtask

	// random phases: new settings, whole subapertures, sometimes a partial tail
	task automatic test_random_stream();
		int unsigned side, n_subaps, n_pix, pick, start;
		logic [tsc_pkg::DATA_W-1:0] data;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_ITEMS) begin
			// one long stretch where neither side idles
			quiet = (pixels_sent - start >= 120) && (pixels_sent - start < 240);
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 99);
				data = $urandom;
				if (pick < 60)
					data[tsc_pkg::SIZE_W-1:0] = tsc_pkg::SIZE_W'($urandom_range(1, 4));
				else if (pick < 90)
					data[tsc_pkg::SIZE_W-1:0] = tsc_pkg::SIZE_W'($urandom_range(5, 8));
				else if (pick < 95)
					data[tsc_pkg::SIZE_W-1:0] = '0;
				else
					data[tsc_pkg::SIZE_W-1:0] = tsc_pkg::SIZE_W'(12);
				cfg_write(tsc_pkg::REG_SUBAP_SIZE, data);
			end
			if ($urandom_range(0, 1) != 0) begin
				pick = $urandom_range(0, 99);
				data = $urandom;
				if (pick < 50)
					data[tsc_pkg::THR_W-1:0] = tsc_pkg::THR_W'($urandom_range(0, 2000));
				else if (pick < 80)
					data[tsc_pkg::THR_W-1:0] = '0;
				else if (pick < 95)
					data[tsc_pkg::THR_W-1:0] = tsc_pkg::THR_W'($urandom_range(0, 262143));
				else
					data[tsc_pkg::THR_W-1:0] = '1;
				cfg_write(tsc_pkg::REG_THRESHOLD, data);
			end
			side = eff_side(size_q);
			n_subaps = (side >= 6) ? 1 : $urandom_range(1, 3);
			n_pix = n_subaps * side * side;
			// a partial tail leaves the next setting to land mid-subaperture
			if (side > 1 && $urandom_range(0, 3) == 0)
				n_pix += $urandom_range(1, side * side - 1);
			repeat (n_pix) send_random_pixel();
			if ($urandom_range(0, 5) == 0)
				drain_all();
		end
		quiet = 1'b0;
		drain_all();
	endtask

	// receiver: check every accepted result, then pick the stall for the next edge
	initial begin : result_monitor
		centroid_rec_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_centroids.size() == 0) begin
					errors++;
					$display("%0t: result item with none owed, x %0d y %0d flux %0d count %0d",
						$time, x_centroid, y_centroid, flux_total, pixel_count);
				end else begin
					want = pending_centroids.pop_front();
					results_seen++;
					check_field("x_centroid", 64'(want.x), 64'(x_centroid));
					check_field("y_centroid", 64'(want.y), 64'(y_centroid));
					check_field("flux_total", 64'(want.flux), 64'(flux_total));
					check_field("pixel_count", 64'(want.count), 64'(pixel_count));
					check_field("centroid_valid", 64'(want.valid), 64'(centroid_valid));
				end
			end
			// long hold-off counted here, otherwise random stalls unless in the quiet stretch
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 36);
		end
	end

	// run limit
	initial begin : watchdog
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_threshold_edges();
		test_size_zero();
		test_mid_subaperture_write();
		test_backpressure();
		test_full_size();
		test_random_stream();
		$display("covered %0d pixel items, %0d subaperture results, %0d register writes",
			pixels_sent, results_seen, reg_writes);
		$display("sizes 0 to 127, thresholds 0 to max, a full-queue stall, %0d cycles",
			cycle_cnt);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
